/* rtl/rilu_pkg.sv */
package rilu_pkg;

  localparam int NUM_SNAPSHOT_REGS_DEF = 16;
  localparam int REG_IDX_W = 4;
  localparam int VALUE_W = 64;
  localparam int WORD_W = 16;
  localparam int MAP_W = 10;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] WORD_DROPPED = 16'hFFFF;
  localparam logic [WORD_W-1:0] VIOLATION_MARK = 16'h0002;
  localparam logic [REG_IDX_W-1:0] SKIP_REG_RESET = 4'd4;

  localparam logic [2:0] REL_EQ = 3'd0;
  localparam logic [2:0] REL_LT = 3'd1;
  localparam logic [2:0] REL_LE = 3'd2;
  localparam logic [2:0] REL_GT = 3'd3;
  localparam logic [2:0] REL_GE = 3'd4;
  localparam logic [2:0] REL_NE = 3'd5;
  localparam logic [2:0] REL_UNUSED6 = 3'd6;
  localparam logic [2:0] REL_UNUSED7 = 3'd7;

  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_LEARN_RANGE = 2'd1,
    CMD_LEARN_PAIR  = 2'd2,
    CMD_CHECK       = 2'd3
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [REG_IDX_W-1:0] first_reg;
    logic [REG_IDX_W-1:0] second_reg;
    logic [VALUE_W-1:0]   reg_value;
    logic [WORD_W-1:0]    inv_word_in;
  } cmd_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] inv_word_out;
    logic              changed;
  } res_item_t;

  typedef struct packed {
    cmd_code_t            op;
    logic [REG_IDX_W-1:0] reg_a;
    logic [REG_IDX_W-1:0] reg_b;
    logic [VALUE_W-1:0]   value;
    logic [WORD_W-1:0]    word;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_status_t;

  typedef struct packed {
    logic       keep;
    logic [2:0] rel;
  } relax_t;

  function automatic logic [VALUE_W-1:0] bucket_low(input logic [3:0] idx);
    case (idx)
      4'd0:    return 64'h0000_0000_0000_0000;
      4'd1:    return 64'h0000_0000_0000_0010;
      4'd2:    return 64'h0000_0000_0000_0100;
      4'd3:    return 64'h0000_0000_0001_0000;
      4'd4:    return 64'h0000_0001_0000_0000;
      4'd5:    return 64'h8000_0000_0000_0000;
      4'd6:    return 64'hFFFF_FFFF_0000_0000;
      4'd7:    return 64'hFFFF_FFFF_FFFF_0000;
      4'd8:    return 64'hFFFF_FFFF_FFFF_FF00;
      4'd9:    return 64'hFFFF_FFFF_FFFF_FFF0;
      default: return 64'h0000_0000_0000_0000;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] bucket_high(input logic [3:0] idx);
    case (idx)
      4'd0:    return 64'h0000_0000_0000_000F;
      4'd1:    return 64'h0000_0000_0000_00FF;
      4'd2:    return 64'h0000_0000_0000_FFFF;
      4'd3:    return 64'h0000_0000_FFFF_FFFF;
      4'd4:    return 64'h7FFF_FFFF_FFFF_FFFF;
      4'd5:    return 64'hFFFF_FFFE_FFFF_FFFF;
      4'd6:    return 64'hFFFF_FFFF_FFFE_FFFF;
      4'd7:    return 64'hFFFF_FFFF_FFFF_FEFF;
      4'd8:    return 64'hFFFF_FFFF_FFFF_FFEF;
      4'd9:    return 64'hFFFF_FFFF_FFFF_FFFF;
      default: return 64'h0000_0000_0000_0000;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] range_low(input logic [MAP_W-1:0] map);
    logic [VALUE_W-1:0] lo;
    lo = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (map[i]) lo = bucket_low(4'(i));
    end
    return lo;
  endfunction

  function automatic logic [VALUE_W-1:0] range_high(input logic [MAP_W-1:0] map);
    logic [VALUE_W-1:0] hi;
    hi = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (map[i]) hi = bucket_high(4'(i));
    end
    return hi;
  endfunction

  function automatic logic [WORD_W-1:0] bucket_bit(input logic [VALUE_W-1:0] v);
    logic [3:0] pos;
    if (!v[63]) begin
      if (v < 64'h10) pos = 4'd6;
      else if (v < 64'h100) pos = 4'd7;
      else if (v < 64'h1_0000) pos = 4'd8;
      else if (v < 64'h1_0000_0000) pos = 4'd9;
      else pos = 4'd10;
    end else begin
      if (v >= 64'hFFFF_FFFF_FFFF_FFF0) pos = 4'd15;
      else if (v >= 64'hFFFF_FFFF_FFFF_FF00) pos = 4'd14;
      else if (v >= 64'hFFFF_FFFF_FFFF_0000) pos = 4'd13;
      else if (v >= 64'hFFFF_FFFF_0000_0000) pos = 4'd12;
      else pos = 4'd11;
    end
    return 16'(1) << pos;
  endfunction

  function automatic relax_t relax(input logic [2:0] rel, input logic [VALUE_W-1:0] a,
                                   input logic [VALUE_W-1:0] b);
    relax_t r;
    logic eq;
    logic lt;
    eq = (a == b);
    lt = (a < b);
    r.keep = 1'b1;
    r.rel = rel;
    case (rel)
      REL_EQ: r.rel = eq ? REL_EQ : (lt ? REL_LE : REL_GE);
      REL_LT: r.rel = lt ? REL_LT : (eq ? REL_LE : REL_NE);
      REL_LE: r.keep = lt || eq;
      REL_GT: r.rel = (!lt && !eq) ? REL_GT : (eq ? REL_GE : REL_NE);
      REL_GE: r.keep = !lt;
      REL_NE: r.keep = !eq;
      default: r.keep = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/rilu_front.sv */
module rilu_front
  import rilu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_data,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_item_t            cmd,
  input  queue_status_t        q_status,
  output logic                 push,
  output queue_entry_t         push_entry
);

  logic [REG_IDX_W-1:0] skip_register;
  logic                 skipped;
  cmd_code_t            op;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_register <= SKIP_REG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      skip_register <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign cmd_stall = q_status.full;
  assign op = cmd_code_t'(cmd.command);

  // drop learn-range on the skipped register: no result, no state change
  assign skipped = (op == CMD_LEARN_RANGE) && (cmd.first_reg == skip_register);
  assign push = cmd_valid && !q_status.full && !skipped;

  always_comb begin
    push_entry.op = op;
    push_entry.value = cmd.reg_value;
    push_entry.word = cmd.inv_word_in;
    push_entry.reg_a = cmd.first_reg;
    push_entry.reg_b = cmd.second_reg;
    if (op == CMD_CHECK) begin
      push_entry.reg_a = cmd.inv_word_in[5:2];
      push_entry.reg_b = cmd.inv_word_in[12:9];
    end
  end

endmodule

/* rtl/rilu_queue.sv */
module rilu_queue
  import rilu_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_entry_t  push_entry,
  input  logic          pop,
  output queue_entry_t  head,
  output queue_status_t status
);

  queue_entry_t           slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_pop;

  assign do_pop = pop && (count != '0);
  assign head = slots[rd_ptr];
  assign status.valid = (count != '0);
  assign status.full = (count == QUEUE_CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/rilu_back.sv */
module rilu_back
  import rilu_pkg::*;
#(
  parameter int NUM_SNAPSHOT_REGS = NUM_SNAPSHOT_REGS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  queue_entry_t  head,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_stall,
  output res_item_t     res
);

  localparam int ADDR_W = (NUM_SNAPSHOT_REGS > 1) ? $clog2(NUM_SNAPSHOT_REGS) : 1;

  logic [VALUE_W-1:0] snapshot [NUM_SNAPSHOT_REGS];

  logic               exe_valid;
  queue_entry_t       exe_entry;
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;
  logic               a_ok;
  logic               b_ok;
  logic               out_free;
  logic               head_a_ok;
  logic               head_b_ok;
  logic [VALUE_W-1:0] a_val;
  logic [VALUE_W-1:0] b_val;
  logic [WORD_W-1:0]  word_next;
  logic               changed_next;
  logic [WORD_W-1:0]  w;
  relax_t             rx;
  logic [2:0]         pair_rel;

  assign out_free = !res_valid || !res_stall;
  assign pop = q_status.valid && (!exe_valid || out_free);

  assign head_a_ok = ({1'b0, head.reg_a} < (REG_IDX_W + 1)'(NUM_SNAPSHOT_REGS));
  assign head_b_ok = ({1'b0, head.reg_b} < (REG_IDX_W + 1)'(NUM_SNAPSHOT_REGS));

  always_ff @(posedge clk) begin
    if (pop && head.op == CMD_WRITE && head_a_ok) begin
      snapshot[head.reg_a[ADDR_W-1:0]] <= head.value;
    end
    if (pop) begin
      rd_a <= snapshot[head.reg_a[ADDR_W-1:0]];
      rd_b <= snapshot[head.reg_b[ADDR_W-1:0]];
      a_ok <= head_a_ok;
      b_ok <= head_b_ok;
      exe_entry <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exe_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        exe_valid <= (head.op != CMD_WRITE);
      end else if (out_free) begin
        exe_valid <= 1'b0;
      end
      if (exe_valid && out_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exe_valid && out_free) begin
      res.inv_word_out <= word_next;
      res.changed <= changed_next;
    end
  end

  assign a_val = a_ok ? rd_a : '0;
  assign b_val = b_ok ? rd_b : '0;
  assign w = exe_entry.word;
  assign rx = relax(w[8:6], a_val, b_val);
  assign pair_rel = (a_val == b_val) ? REL_EQ : ((a_val < b_val) ? REL_LT : REL_GT);

  always_comb begin
    word_next = w;
    changed_next = 1'b0;
    case (exe_entry.op)
      CMD_LEARN_RANGE: begin
        word_next = {{(WORD_W - REG_IDX_W - 2){1'b0}}, exe_entry.reg_a, 2'b01}
                    | bucket_bit(a_val);
      end
      CMD_LEARN_PAIR: begin
        word_next = {3'b000, exe_entry.reg_b, pair_rel, exe_entry.reg_a, 2'b00};
      end
      CMD_CHECK: begin
        if (w == WORD_DROPPED) begin
          word_next = w;
        end else if (!w[0]) begin
          if (!rx.keep) begin
            word_next = WORD_DROPPED;
            changed_next = 1'b1;
          end else if (rx.rel != w[8:6]) begin
            word_next = {w[15:9], rx.rel, w[5:2], 1'b1, w[0]};
            changed_next = 1'b1;
          end
        end else if ((a_val < range_low(w[15:6])) || (a_val > range_high(w[15:6]))) begin
          word_next = w | bucket_bit(a_val) | VIOLATION_MARK;
          changed_next = 1'b1;
        end
      end
      default: begin
        word_next = w;
        changed_next = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/register_invariant_learner_unit.sv */
// Commands pass a queue slot, the execute stage and the result register.
// Throughput: one command per cycle while cmd_stall is low, set by the
// single-ported snapshot write and the one-pop-per-cycle command queue feeding
// the execute stage. Writes and skipped learn-range commands give no result.
// Reset (rst, synchronous): empties the queue and pipeline, skip register to 4.
// The register snapshot is not cleared; it holds no defined value until written.
module register_invariant_learner_unit
  import rilu_pkg::*;
#(
  parameter int NUM_SNAPSHOT_REGS = NUM_SNAPSHOT_REGS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_data,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_item_t            cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_item_t            res
);

  queue_status_t q_status;
  logic          push;
  queue_entry_t  push_entry;
  logic          pop;
  queue_entry_t  head;

  rilu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  rilu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  rilu_back #(
    .NUM_SNAPSHOT_REGS (NUM_SNAPSHOT_REGS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

/* rtl/rilu_checker.sv */
module rilu_checker
  import rilu_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_stall,
  input res_item_t res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result shown right after reset");

  a_changed_marked: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.changed |->
      res.inv_word_out[1] || (res.inv_word_out == WORD_DROPPED))
    else $error("changed word without violation mark");

  a_pair_rel_valid: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.inv_word_out[0] && (res.inv_word_out != WORD_DROPPED) |->
      (res.inv_word_out[8:6] != REL_UNUSED6) && (res.inv_word_out[8:6] != REL_UNUSED7))
    else $error("pair word with meaningless relation");

endmodule

bind register_invariant_learner_unit rilu_checker u_rilu_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res       (res)
);

/* tb/register_invariant_learner_unit_checker.sv */
module register_invariant_learner_unit_checker
  import rilu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_data,
  input  logic                 cmd_valid,
  input  logic                 cmd_stall,
  input  cmd_item_t            cmd,
  input  logic                 res_valid,
  input  logic                 res_stall,
  input  res_item_t            res,
  output int                   failures,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [VALUE_W-1:0]   snapshot_copy [16];
  logic [REG_IDX_W-1:0] skip_copy;
  res_item_t            expected_words [$];

  initial begin
    failures = 0;
    pending = 0;
    skip_copy = SKIP_REG_RESET;
  end

  function automatic logic [VALUE_W-1:0] bucket_floor(input int k);
    case (k)
      0: return 64'h0;
      1: return 64'h10;
      2: return 64'h100;
      3: return 64'h1_0000;
      4: return 64'h1_0000_0000;
      5: return 64'h8000_0000_0000_0000;
      6: return ~64'hFFFF_FFFF;
      7: return ~64'hFFFF;
      8: return ~64'hFF;
      default: return ~64'hF;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] bucket_ceiling(input int k);
    if (k >= MAP_W - 1) return ~64'h0;
    return bucket_floor(k + 1) - 64'd1;
  endfunction

  function automatic int bucket_pos(input logic [VALUE_W-1:0] v);
    for (int k = MAP_W - 1; k > 0; k--) begin
      if (v >= bucket_floor(k)) return k;
    end
    return 0;
  endfunction

  function automatic res_item_t check_word(input logic [WORD_W-1:0] w);
    res_item_t          r;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    logic [2:0]         rel;
    logic [2:0]         nrel;
    logic               keep;
    logic [MAP_W-1:0]   map;
    int                 first;
    int                 last;
    r.inv_word_out = w;
    r.changed = 1'b0;
    if (w == WORD_DROPPED) return r;
    a = snapshot_copy[w[5:2]];
    if (!w[0]) begin
      rel = w[8:6];
      b = snapshot_copy[w[12:9]];
      nrel = rel;
      keep = 1'b1;
      case (rel)
        REL_EQ: nrel = (a == b) ? REL_EQ : (a < b) ? REL_LE : REL_GE;
        REL_LT: nrel = (a < b) ? REL_LT : (a == b) ? REL_LE : REL_NE;
        REL_LE: keep = (a <= b);
        REL_GT: nrel = (a > b) ? REL_GT : (a == b) ? REL_GE : REL_NE;
        REL_GE: keep = (a >= b);
        REL_NE: keep = (a != b);
        default: keep = 1'b0;
      endcase
      if (!keep) begin
        r.inv_word_out = WORD_DROPPED;
        r.changed = 1'b1;
      end else if (nrel != rel) begin
        r.inv_word_out = w | VIOLATION_MARK;
        r.inv_word_out[8:6] = nrel;
        r.changed = 1'b1;
      end
    end else begin
      map = w[15:6];
      lo = '0;
      hi = '0;
      if (map != '0) begin
        first = -1;
        last = 0;
        for (int i = 0; i < MAP_W; i++) begin
          if (map[i]) begin
            if (first < 0) first = i;
            last = i;
          end
        end
        lo = bucket_floor(first);
        hi = bucket_ceiling(last);
      end
      if (a < lo || a > hi) begin
        r.inv_word_out = w | VIOLATION_MARK | (16'd1 << (bucket_pos(a) + 6));
        r.changed = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic bit outcome(input cmd_item_t c, output res_item_t r);
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    r = '0;
    case (c.command)
      CMD_WRITE: begin
        snapshot_copy[c.first_reg] = c.reg_value;
        return 1'b0;
      end
      CMD_LEARN_RANGE: begin
        if (c.first_reg == skip_copy) return 1'b0;
        r.inv_word_out = 16'h0001 | (16'(c.first_reg) << 2)
                       | (16'd1 << (bucket_pos(snapshot_copy[c.first_reg]) + 6));
      end
      CMD_LEARN_PAIR: begin
        a = snapshot_copy[c.first_reg];
        b = snapshot_copy[c.second_reg];
        r.inv_word_out = {3'b000, c.second_reg,
                          (a == b) ? REL_EQ : (a < b) ? REL_LT : REL_GT,
                          c.first_reg, 2'b00};
      end
      default: r = check_word(c.inv_word_in);
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      expected_words.delete();
      skip_copy = SKIP_REG_RESET;
    end else begin
      if (cfg_valid && cfg_ready) skip_copy = cfg_data;
      if (res_valid && !res_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual word %h changed %b",
                   $time, res.inv_word_out, res.changed);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (res.inv_word_out !== want.inv_word_out) begin
            $display("%0t: inv_word_out expected %h actual %h",
                     $time, want.inv_word_out, res.inv_word_out);
            failures++;
          end
          if (res.changed !== want.changed) begin
            $display("%0t: changed expected %b actual %b", $time, want.changed, res.changed);
            failures++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (outcome(cmd, want)) expected_words.push_back(want);
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/register_invariant_learner_unit_test.sv */
module register_invariant_learner_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rilu_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASES = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 10;
  localparam int POOL_DEPTH = 64;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [REG_IDX_W-1:0] cfg_data;
  logic                 cmd_valid;
  logic                 cmd_stall;
  cmd_item_t            cmd;
  logic                 res_valid;
  logic                 res_stall;
  res_item_t            res;
  int                   failures;
  int                   pending;
  int                   quiet_cycles = 0;
  bit                   calm;
  bit                   hold_start;
  bit                   hold_done;
  logic [REG_IDX_W-1:0] skip_now;
  logic [VALUE_W-1:0]   values_seen [16];
  logic [WORD_W-1:0]    word_pool [$];

  always #1 clk = ~clk;

  register_invariant_learner_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  register_invariant_learner_unit_checker prediction_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .failures  (failures),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // recycle produced words as later check inputs
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (word_pool.size() >= POOL_DEPTH) word_pool.delete(0);
      word_pool.push_back(res.inv_word_out);
    end
  end

  initial begin
    int n;
    res_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_start && !hold_done) begin
        hold_done = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        res_stall <= 1'b1;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    int                 sh;
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(1, 63);
      2: v = 64'($urandom_range(0, 20));
      3: v = ~64'($urandom_range(0, 20));
      4: begin
        case ($urandom_range(0, 4))
          0: sh = 4;
          1: sh = 8;
          2: sh = 16;
          3: sh = 32;
          default: sh = 63;
        endcase
        v = $urandom_range(0, 1) ? (64'd1 << sh) : (~64'd0 << sh);
        v = v - 64'($urandom_range(0, 1));
      end
      default: v = values_seen[$urandom_range(0, 15)];
    endcase
    return v;
  endfunction

  task automatic issue(input cmd_code_t op, input logic [REG_IDX_W-1:0] r1,
                       input logic [REG_IDX_W-1:0] r2, input logic [VALUE_W-1:0] value,
                       input logic [WORD_W-1:0] word);
    cmd_item_t c;
    int        gap;
    bit        taken;
    c.command = op;
    c.first_reg = r1;
    c.second_reg = r2;
    c.reg_value = value;
    c.inv_word_in = word;
    if (op == CMD_WRITE) values_seen[r1] = value;
    if (!calm && $urandom_range(0, 7) == 0) begin
      cmd_valid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !cmd_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [VALUE_W-1:0]   v;
    logic [WORD_W-1:0]    w;
    logic [MAP_W-1:0]     map;
    logic [REG_IDX_W-1:0] r1;
    cmd_code_t            op;
    bit                   taken;
    int                   k;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    cmd_valid <= 1'b0;
    cmd <= '0;
    skip_now = SKIP_REG_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 16; i++) begin
      case (i)
        0, 8: v = 64'h0;
        1: v = ~64'h0;
        2: v = 64'hF;
        3: v = 64'h10;
        4: v = 64'h8000_0000_0000_0000;
        5: v = 64'h7FFF_FFFF_FFFF_FFFF;
        6: v = 64'hFFFF_FFFF_0000_0000;
        7: v = 64'hFFFF_FFFE_FFFF_FFFF;
        9: v = 64'hFFFF_FFFF_FFFF_FFF0;
        10: v = 64'h1_0000_0000;
        11: v = 64'hFFFF;
        12: v = 64'hFFFF_FFFF_FFFF_0000;
        13: v = 64'hFFFF_FFFF_FFFF_FF00;
        14: v = 64'h100;
        default: v = 64'h1_0000;
      endcase
      issue(CMD_WRITE, 4'(i), 4'($urandom), v, 16'($urandom));
    end

    issue(CMD_LEARN_RANGE, 4'd1, 4'($urandom), {$urandom, $urandom}, 16'($urandom));
    issue(CMD_LEARN_RANGE, SKIP_REG_RESET, 4'($urandom), {$urandom, $urandom}, 16'($urandom));
    issue(CMD_LEARN_PAIR, 4'd0, 4'd8, {$urandom, $urandom}, 16'($urandom));
    issue(CMD_LEARN_PAIR, 4'd0, 4'd1, {$urandom, $urandom}, 16'($urandom));
    issue(CMD_LEARN_PAIR, 4'd1, 4'd0, {$urandom, $urandom}, 16'($urandom));
    issue(CMD_CHECK, 4'd0, 4'd0, {$urandom, $urandom}, WORD_DROPPED);
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd1, REL_UNUSED6, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b111, 4'd0, REL_UNUSED7, 4'd1, 2'b10});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd1, REL_EQ, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b101, 4'd8, REL_EQ, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd0, REL_LT, 4'd1, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd8, REL_LT, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd0, REL_LE, 4'd1, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd8, REL_GT, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b010, 4'd1, REL_GT, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd1, REL_GE, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {3'b000, 4'd8, REL_NE, 4'd0, 2'b00});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {10'h000, 4'd0, 2'b01});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {10'h000, 4'd2, 2'b01});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {10'h001, 4'd1, 2'b11});
    issue(CMD_CHECK, 4'd0, 4'd0, '0, {10'h3FF, 4'd5, 2'b01});

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) calm = 1'b1;
      drain();
      skip_now = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom);
      cfg_data <= skip_now;
      cfg_valid <= 1'b1;
      do begin
        @(negedge clk);
        taken = cfg_ready;
        @(posedge clk);
      end while (!taken);
      cfg_valid <= 1'b0;
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (p == 2 && n == 40) hold_start = 1'b1;
        k = $urandom_range(0, 99);
        op = (k < 25) ? CMD_WRITE : (k < 45) ? CMD_LEARN_RANGE :
             (k < 65) ? CMD_LEARN_PAIR : CMD_CHECK;
        r1 = 4'($urandom);
        w = 16'($urandom);
        if (op == CMD_LEARN_RANGE && $urandom_range(0, 3) == 0) r1 = skip_now;
        if (op == CMD_CHECK) begin
          case ($urandom_range(0, 9))
            0: w = WORD_DROPPED;
            1, 2, 3: begin
              if (word_pool.size() > 0) w = word_pool[$urandom_range(0, word_pool.size() - 1)];
            end
            4, 5, 6: begin
              w = {3'($urandom), 4'($urandom),
                   ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5)),
                   4'($urandom), 1'($urandom), 1'b0};
            end
            7, 8: begin
              case ($urandom_range(0, 3))
                0: map = '0;
                1: map = 10'd1 << $urandom_range(0, 9);
                default: map = 10'($urandom);
              endcase
              w = {map, 4'($urandom), 1'($urandom), 1'b1};
            end
            default: w = 16'($urandom);
          endcase
        end
        issue(op, r1, 4'($urandom), pick_value(), w);
      end
    end

    drain();
    if (failures == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
